// ===== sv/ubx_frame_receiver_top_assert.svh =====
// assertion macros for the ubx frame receiver
`ifndef UBX_FRAME_RECEIVER_TOP_ASSERT_SVH
`define UBX_FRAME_RECEIVER_TOP_ASSERT_SVH

// condition in the same cycle
`define UBXFR_ASSERT_SAME(lbl, clk, rst, cond, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// condition in the next cycle
`define UBXFR_ASSERT_NEXT(lbl, clk, rst, cond, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== sv/ubxfr_pkg.sv =====
package ubxfr_pkg;

   localparam logic [7:0] SYNC_CHAR_1 = 8'hB5;
   localparam logic [7:0] SYNC_CHAR_2 = 8'h62;

   typedef enum logic [3:0] {
      PH_HUNT  = 4'd0,
      PH_SYNC2 = 4'd1,
      PH_CLASS = 4'd2,
      PH_IDENT = 4'd3,
      PH_LENLO = 4'd4,
      PH_LENHI = 4'd5,
      PH_PAY   = 4'd6,
      PH_CKA   = 4'd7,
      PH_CKB   = 4'd8
   } phase_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_DONE    = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  msg_class;
      logic [7:0]  msg_ident;
      logic [7:0]  payload_byte;
      logic [15:0] payload_offset;
      logic [15:0] frame_length;
      logic        checksum_ok;
   } rsp_data_type;

endpackage

// ===== sv/ubxfr_req_if.sv =====
interface ubxfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/ubxfr_rsp_if.sv =====
interface ubxfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  msg_class;
   logic [7:0]  msg_ident;
   logic [7:0]  payload_byte;
   logic [15:0] payload_offset;
   logic [15:0] frame_length;
   logic        checksum_ok;

   modport source (
      output valid, output kind, output msg_class, output msg_ident,
      output payload_byte, output payload_offset, output frame_length,
      output checksum_ok, input ready
   );
   modport sink (
      input valid, input kind, input msg_class, input msg_ident,
      input payload_byte, input payload_offset, input frame_length,
      input checksum_ok, output ready
   );
endinterface

// ===== sv/ubxfr_in_stage.sv =====
module ubxfr_in_stage (
   input  logic       clock,
   input  logic       reset,
   ubxfr_req_if.sink  req_chan,
   input  logic       advance,
   output logic       in_valid,
   output logic [7:0] in_byte
);
   import ubxfr_pkg::*;

   logic       valid_ff;
   logic [7:0] byte_ff;

   assign req_chan.ready = !valid_ff || advance;
   assign in_valid       = valid_ff;
   assign in_byte        = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         byte_ff <= req_chan.rx_byte;
      end
   end
endmodule

// ===== sv/ubxfr_parser.sv =====
module ubxfr_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              rx_byte,
   output logic                    res_valid,
   output ubxfr_pkg::rsp_data_type res
);
   import ubxfr_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  ident_ff, ident_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  check_ff, check_in;
   logic [7:0]  sum_a_add;
   logic [7:0]  sum_b_add;
   logic        emit;
   logic        last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

   // sums restart at every preamble, header fields before first use
   always_ff @(posedge clock) begin
      if (step) begin
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         class_ff  <= class_in;
         ident_ff  <= ident_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         check_ff  <= check_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      class_in  = class_ff;
      ident_in  = ident_ff;
      length_in = length_ff;
      count_in  = count_ff;
      check_in  = check_ff;
      emit      = 1'b0;
      sum_a_add = sum_a_ff + rx_byte;
      sum_b_add = sum_b_ff + sum_a_add;
      last_byte = ({1'b0, count_ff} + 17'd1) >= {1'b0, length_ff};

      res.kind           = KIND_PAYLOAD;
      res.msg_class      = class_ff;
      res.msg_ident      = ident_ff;
      res.payload_byte   = 8'd0;
      res.payload_offset = 16'd0;
      res.frame_length   = length_ff;
      res.checksum_ok    = 1'b0;

      unique case (phase_ff)
         PH_SYNC2: begin
            if (rx_byte == SYNC_CHAR_2) begin
               phase_in = PH_CLASS;
               sum_a_in = 8'd0;
               sum_b_in = 8'd0;
            end else if (rx_byte != SYNC_CHAR_1) begin
               phase_in = PH_HUNT;
            end
         end
         PH_CLASS: begin
            class_in = rx_byte;
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            phase_in = PH_IDENT;
         end
         PH_IDENT: begin
            ident_in = rx_byte;
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            length_in = {8'd0, rx_byte};
            sum_a_in  = sum_a_add;
            sum_b_in  = sum_b_add;
            phase_in  = PH_LENHI;
         end
         PH_LENHI: begin
            length_in = {rx_byte, length_ff[7:0]};
            sum_a_in  = sum_a_add;
            sum_b_in  = sum_b_add;
            count_in  = 16'd0;
            // empty payload skips straight to the checksum
            phase_in  = ({rx_byte, length_ff[7:0]} == 16'd0) ? PH_CKA : PH_PAY;
         end
         PH_PAY: begin
            sum_a_in           = sum_a_add;
            sum_b_in           = sum_b_add;
            emit               = 1'b1;
            res.payload_byte   = rx_byte;
            res.payload_offset = count_ff;
            count_in           = count_ff + 16'd1;
            if (last_byte) begin
               phase_in = PH_CKA;
            end
         end
         PH_CKA: begin
            check_in = rx_byte;
            phase_in = PH_CKB;
         end
         PH_CKB: begin
            emit            = 1'b1;
            res.kind        = KIND_DONE;
            res.checksum_ok = (check_ff == sum_a_ff) && (rx_byte == sum_b_ff);
            phase_in        = PH_HUNT;
         end
         default: begin
            // hunting, unused codes included
            phase_in = (rx_byte == SYNC_CHAR_1) ? PH_SYNC2 : PH_HUNT;
         end
      endcase
   end

   assign res_valid = step && emit;
endmodule

// ===== sv/ubxfr_out_stage.sv =====
module ubxfr_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_valid,
   input  ubxfr_pkg::rsp_data_type load_data,
   output logic                    advance,
   ubxfr_rsp_if.source             rsp_chan
);
   import ubxfr_pkg::*;

   logic         valid_ff;
   rsp_data_type data_ff;

   assign advance = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.kind           = data_ff.kind;
   assign rsp_chan.msg_class      = data_ff.msg_class;
   assign rsp_chan.msg_ident      = data_ff.msg_ident;
   assign rsp_chan.payload_byte   = data_ff.payload_byte;
   assign rsp_chan.payload_offset = data_ff.payload_offset;
   assign rsp_chan.frame_length   = data_ff.frame_length;
   assign rsp_chan.checksum_ok    = data_ff.checksum_ok;
endmodule

// ===== sv/ubx_frame_receiver_top.sv =====
// UBX frame receiver: takes one received byte per transfer, hunts for the
// 0xB5 0x62 preamble, and for every frame gives one result per payload byte
// (kind 0, with the byte and its offset) and then one frame-done result
// (kind 1) carrying class, ID, length and whether the Fletcher checksum
// matched. The frame-done result comes with the second checksum byte; the
// preamble, the header and the first checksum byte give no result. It takes
// one byte every cycle unless stalled. A byte waits in the input register
// after its transfer and is parsed there; its result goes to the result
// register when the parser steps. The request side stalls only while both
// the input and the result register are full and the result is not taken.
module ubx_frame_receiver_top (
   input logic         clock,
   input logic         reset,
   ubxfr_req_if.sink   req_chan,
   ubxfr_rsp_if.source rsp_chan
);
   import ubxfr_pkg::*;

   logic         advance;
   logic         in_valid;
   logic [7:0]   in_byte;
   logic         step;
   logic         res_valid;
   rsp_data_type res;

   assign step = in_valid && advance;

   ubxfr_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .in_valid (in_valid),
      .in_byte  (in_byte)
   );

   ubxfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   ubxfr_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load_valid (res_valid),
      .load_data  (res),
      .advance    (advance),
      .rsp_chan   (rsp_chan)
   );

`include "ubx_frame_receiver_top_assert.svh"

   `UBXFR_ASSERT_NEXT(a_result_reaches_output, clock, reset, res_valid,
      rsp_chan.valid && rsp_chan.kind == $past(res.kind)
         && rsp_chan.payload_offset == $past(res.payload_offset),
      "parsed result lost before output register")
   `UBXFR_ASSERT_NEXT(a_input_held_on_stall, clock, reset, in_valid && !advance,
      in_valid && $stable(in_byte), "buffered byte dropped during stall")
   `UBXFR_ASSERT_SAME(a_done_fields_clear, clock, reset, rsp_chan.valid,
      (rsp_chan.kind == KIND_DONE)
         ? (rsp_chan.payload_byte == 8'd0 && rsp_chan.payload_offset == 16'd0)
         : (rsp_chan.checksum_ok == 1'b0),
      "result fields inconsistent with kind")
endmodule

// ===== test/ubx_frame_receiver_top_tb.sv =====
module ubx_frame_receiver_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ubxfr_pkg::*;

   // running frame parser mirror and the results it still waits for
   class ubx_frame_checker;
      phase_type    phase;
      logic [7:0]   sum_a;
      logic [7:0]   sum_b;
      logic [7:0]   held_class;
      logic [7:0]   held_ident;
      logic [15:0]  held_length;
      logic [15:0]  byte_count;
      logic [7:0]   first_check;
      rsp_data_type frame_results_q[$];
      int           errors;

      function new();
         phase       = PH_HUNT;
         sum_a       = '0;
         sum_b       = '0;
         held_class  = '0;
         held_ident  = '0;
         held_length = '0;
         byte_count  = '0;
         first_check = '0;
         errors      = 0;
      endfunction

      function void fold_sum(logic [7:0] b);
         sum_a = sum_a + b;
         sum_b = sum_b + sum_a;
      endfunction

      function void push_result(kind_type k, logic [7:0] pbyte, logic [15:0] poff, logic ok);
         rsp_data_type e;
         e.kind           = k;
         e.msg_class      = held_class;
         e.msg_ident      = held_ident;
         e.payload_byte   = pbyte;
         e.payload_offset = poff;
         e.frame_length   = held_length;
         e.checksum_ok    = ok;
         frame_results_q = {frame_results_q, e};
      endfunction

      function void note_byte(logic [7:0] b);
         case (phase)
            PH_SYNC2: begin
               if (b == SYNC_CHAR_2) begin
                  phase = PH_CLASS;
                  sum_a = '0;
                  sum_b = '0;
               end else if (b != SYNC_CHAR_1) begin
                  phase = PH_HUNT;
               end
            end
            PH_CLASS: begin
               held_class = b;
               fold_sum(b);
               phase = PH_IDENT;
            end
            PH_IDENT: begin
               held_ident = b;
               fold_sum(b);
               phase = PH_LENLO;
            end
            PH_LENLO: begin
               held_length = {8'h00, b};
               fold_sum(b);
               phase = PH_LENHI;
            end
            PH_LENHI: begin
               held_length[15:8] = b;
               fold_sum(b);
               byte_count = '0;
               phase = (held_length == 16'h0000) ? PH_CKA : PH_PAY;
            end
            PH_PAY: begin
               fold_sum(b);
               push_result(KIND_PAYLOAD, b, byte_count, 1'b0);
               if ({1'b0, byte_count} + 17'd1 >= {1'b0, held_length})
                  phase = PH_CKA;
               byte_count = byte_count + 16'd1;
            end
            PH_CKA: begin
               first_check = b;
               phase = PH_CKB;
            end
            PH_CKB: begin
               push_result(KIND_DONE, 8'h00, 16'h0000,
                           (first_check == sum_a) && (b == sum_b));
               phase = PH_HUNT;
            end
            default: begin
               phase = (b == SYNC_CHAR_1) ? PH_SYNC2 : PH_HUNT;
            end
         endcase
      endfunction

      function void check_result(rsp_data_type got);
         rsp_data_type e;
         if (frame_results_q.size() == 0) begin
            $display("%0t: unexpected result kind=%0d class=%h id=%h", $time,
                     got.kind, got.msg_class, got.msg_ident);
            errors++;
            return;
         end
         e = frame_results_q.pop_front();
         if (got.kind !== e.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, e.kind, got.kind);
            errors++;
         end
         if (got.msg_class !== e.msg_class) begin
            $display("%0t: msg_class expected %h actual %h", $time, e.msg_class,
                     got.msg_class);
            errors++;
         end
         if (got.msg_ident !== e.msg_ident) begin
            $display("%0t: msg_ident expected %h actual %h", $time, e.msg_ident,
                     got.msg_ident);
            errors++;
         end
         if (got.payload_byte !== e.payload_byte) begin
            $display("%0t: payload_byte expected %h actual %h", $time, e.payload_byte,
                     got.payload_byte);
            errors++;
         end
         if (got.payload_offset !== e.payload_offset) begin
            $display("%0t: payload_offset expected %0d actual %0d", $time,
                     e.payload_offset, got.payload_offset);
            errors++;
         end
         if (got.frame_length !== e.frame_length) begin
            $display("%0t: frame_length expected %0d actual %0d", $time,
                     e.frame_length, got.frame_length);
            errors++;
         end
         if (got.checksum_ok !== e.checksum_ok) begin
            $display("%0t: checksum_ok expected %0d actual %0d", $time, e.checksum_ok,
                     got.checksum_ok);
            errors++;
         end
      endfunction

      function int pending();
         return frame_results_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   ubxfr_req_if req_chan();
   ubxfr_rsp_if rsp_chan();

   ubx_frame_receiver_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ubx_frame_checker score = new();

   bit quiet;
   bit rsp_hold;
   int items_sent;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      score.note_byte(b);
      items_sent++;
   endtask

   task automatic send_summed(inout logic [7:0] ca, inout logic [7:0] cb,
                              input logic [7:0] b);
      ca = ca + b;
      cb = cb + ca;
      send_byte(b);
   endtask

   // fill below zero gives random payload; bad_ck bit 0 spoils CK_A, bit 1 CK_B
   task automatic send_frame(input logic [7:0] cls, input logic [7:0] ident,
                             input logic [15:0] len, input int fill,
                             input logic [1:0] bad_ck);
      logic [7:0] ca;
      logic [7:0] cb;
      int         i;
      ca = 8'h00;
      cb = 8'h00;
      send_byte(SYNC_CHAR_1);
      send_byte(SYNC_CHAR_2);
      send_summed(ca, cb, cls);
      send_summed(ca, cb, ident);
      send_summed(ca, cb, len[7:0]);
      send_summed(ca, cb, len[15:8]);
      for (i = 0; i < len; i++)
         send_summed(ca, cb, (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
      if (bad_ck[0]) ca = ca ^ (8'h01 << $urandom_range(0, 7));
      if (bad_ck[1]) cb = cb ^ (8'h01 << $urandom_range(0, 7));
      send_byte(ca);
      send_byte(cb);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (score.pending() > 0) @(posedge clock);
   endtask

   // result side: random stalls, plus the long hold-off below
   initial begin
      int stall_left;
      rsp_data_type got;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.kind           = kind_type'(rsp_chan.kind);
            got.msg_class      = rsp_chan.msg_class;
            got.msg_ident      = rsp_chan.msg_ident;
            got.payload_byte   = rsp_chan.payload_byte;
            got.payload_offset = rsp_chan.payload_offset;
            got.frame_length   = rsp_chan.frame_length;
            got.checksum_ok    = rsp_chan.checksum_ok;
            score.check_result(got);
         end
         if (reset || rsp_hold) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = quiet ? 0 : pick_gap();
         end
      end
   end

   // long receiver hold-off while the sender keeps offering bytes
   initial begin
      rsp_hold = 1'b0;
      wait (items_sent >= 400);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #18_000_000;
      $display("ubx_frame_receiver_top: mismatch");
      $finish;
   end

   initial begin
      int r;
      int n;
      int k;
      logic [15:0] len;
      bit big_done;
      bit pause_done;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      quiet            = 1'b0;
      items_sent       = 0;
      big_done         = 1'b0;
      pause_done       = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // broken preamble, then a stray sync byte before a zero-length frame
      send_byte(SYNC_CHAR_1);
      send_byte(8'h00);
      send_byte(SYNC_CHAR_1);
      send_frame(8'hFF, 8'h00, 16'h0000, 0, 2'b00);
      send_frame(8'h00, 8'hFF, 16'h0001, 8'hFF, 2'b01);
      send_frame(8'h5A, 8'hA5, 16'h0000, 0, 2'b10);

      while (items_sent < 1900) begin
         if (!big_done && items_sent >= 1000) begin
            // one long frame, with idling off to keep it quick
            quiet = 1'b1;
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(400, 600)), -1, 2'b00);
            quiet = 1'b0;
            big_done = 1'b1;
         end
         if (!pause_done && items_sent >= 1500) begin
            wait_drained();
            repeat (4) @(posedge clock);
            pause_done = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 10) begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
         end else if (r < 15) begin
            send_byte(SYNC_CHAR_1);
            send_byte(($urandom_range(0, 1) == 0) ? SYNC_CHAR_1 :
                      8'($urandom_range(0, 97)));
         end else begin
            r = $urandom_range(0, 99);
            if (r < 80) len = 16'($urandom_range(0, 12));
            else if (r < 96) len = 16'($urandom_range(13, 40));
            else len = 16'($urandom_range(256, 300));
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len, -1,
                       ($urandom_range(0, 99) < 85) ? 2'b00 : 2'($urandom_range(1, 3)));
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (score.errors == 0 && score.pending() == 0) begin
         $display("ubx_frame_receiver_top: match");
      end else begin
         $display("ubx_frame_receiver_top: mismatch");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/ubxfr_pkg.sv
sv/ubxfr_req_if.sv
sv/ubxfr_rsp_if.sv
sv/ubxfr_in_stage.sv
sv/ubxfr_parser.sv
sv/ubxfr_out_stage.sv
sv/ubx_frame_receiver_top.sv
test/ubx_frame_receiver_top_tb.sv
